// ----- rtl/core/pq_parity_erasure_rebuild_unit_assert.svh -----
// Assertion macros shared by the P+Q rebuild block
`ifndef PQ_PARITY_ERASURE_REBUILD_UNIT_ASSERT_SVH
`define PQ_PARITY_ERASURE_REBUILD_UNIT_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PQER_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pqer assertion failed");

// expression must never be true outside reset
`define PQER_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pqer forbidden condition seen");

`endif

// ----- rtl/core/pqer_pkg.sv -----
// Types, constants and GF(256) helpers for the P+Q rebuild block
`default_nettype none

package pqer_pkg;

  localparam int ALL_UNITS = 8;
  localparam int UNIT_W    = 3;

  typedef logic [7:0] byte_t;
  typedef byte_t [ALL_UNITS-1:0] column_t;
  typedef logic [UNIT_W-1:0] unit_idx_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_NONE = 2'd0;
  localparam status_t ST_ONE  = 2'd1;
  localparam status_t ST_TWO  = 2'd2;
  localparam status_t ST_MANY = 2'd3;

  localparam logic OP_ENCODE  = 1'b0;
  localparam logic OP_REBUILD = 1'b1;

  localparam byte_t GF_POLY_LO = 8'h1B;
  localparam byte_t GF_GEN     = 8'h03;

  typedef byte_t byte_tbl_t [256];
  typedef byte_t coef_tbl_t [ALL_UNITS];

  // payload that travels down the pipeline with each request
  typedef struct packed {
    status_t   status;
    unit_idx_t idx_a;
    unit_idx_t idx_b;
    column_t   data;
    byte_t     pp;
    byte_t     pout;
    byte_t     qout;
  } pqer_item_t;

  function automatic byte_t gf_mul(input byte_t x, input byte_t y);
    byte_t acc;
    byte_t xs;
    acc = '0;
    xs  = x;
    for (int k = 0; k < 8; k++) begin
      if (y[k]) begin
        acc = acc ^ xs;
      end
      xs = xs[7] ? ({xs[6:0], 1'b0} ^ GF_POLY_LO) : {xs[6:0], 1'b0};
    end
    return acc;
  endfunction

  // inverse via the power table of the generator: inv(g^i) = g^(255-i)
  function automatic byte_tbl_t gf_inv_build();
    byte_tbl_t tbl;
    byte_t     pw [255];
    pw[0] = 8'h01;
    for (int i = 1; i < 255; i++) begin
      pw[i] = gf_mul(pw[i-1], GF_GEN);
    end
    tbl[0] = 8'h00;
    for (int i = 0; i < 255; i++) begin
      tbl[pw[i]] = (i == 0) ? pw[0] : pw[255-i];
    end
    return tbl;
  endfunction

  function automatic coef_tbl_t coef_build();
    coef_tbl_t tbl;
    tbl[0] = 8'h01;
    for (int u = 1; u < ALL_UNITS; u++) begin
      tbl[u] = gf_mul(tbl[u-1], GF_GEN);
    end
    return tbl;
  endfunction

  localparam byte_tbl_t GF_INV = gf_inv_build();
  localparam coef_tbl_t COEF   = coef_build();

endpackage

`default_nettype wire

// ----- rtl/core/pqer_syndrome.sv -----
// First stage: partial P and Q sums, erasure count and lost unit indices
`default_nettype none

module pqer_syndrome #(
  parameter int unsigned NUM_UNITS = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vld_i,
  input  wire logic                op_i,
  input  wire pqer_pkg::column_t   data_i,
  input  wire pqer_pkg::byte_t     pin_i,
  input  wire pqer_pkg::byte_t     qin_i,
  input  wire logic [7:0]          lost_mask_i,
  output logic                     vld_o,
  output pqer_pkg::pqer_item_t     item_o,
  output pqer_pkg::byte_t          qq_o,
  output pqer_pkg::byte_t          cb_o,
  output pqer_pkg::byte_t          cab_o
);
  import pqer_pkg::*;

  logic [ALL_UNITS-1:0] erased;
  logic [3:0]           cnt;
  unit_idx_t            idx_a, idx_b;
  byte_t                pp, qq;
  pqer_item_t           item_d;
  logic                 vld_q;
  pqer_item_t           item_q;
  byte_t                qq_q, cb_q, cab_q;

  always_comb begin
    erased = '0;
    pp     = (op_i == OP_REBUILD) ? pin_i : 8'h00;
    qq     = (op_i == OP_REBUILD) ? qin_i : 8'h00;
    cnt    = '0;
    idx_a  = '0;
    idx_b  = '0;
    for (int u = 0; u < ALL_UNITS; u++) begin
      if (u < NUM_UNITS) begin
        erased[u] = lost_mask_i[u] && (op_i == OP_REBUILD);
        if (erased[u]) begin
          if (cnt == 4'd0) begin
            idx_a = UNIT_W'(u);
          end else if (cnt == 4'd1) begin
            idx_b = UNIT_W'(u);
          end
          cnt = cnt + 4'd1;
        end else begin
          pp = pp ^ data_i[u];
          qq = qq ^ gf_mul(COEF[u], data_i[u]);
        end
      end
    end

    item_d.idx_a = idx_a;
    item_d.idx_b = idx_b;
    item_d.data  = data_i;
    item_d.pp    = pp;
    item_d.pout  = (op_i == OP_REBUILD) ? pin_i : pp;
    item_d.qout  = (op_i == OP_REBUILD) ? qin_i : qq;
    case (cnt)
      4'd0:    item_d.status = ST_NONE;
      4'd1:    item_d.status = ST_ONE;
      4'd2:    item_d.status = ST_TWO;
      default: item_d.status = ST_MANY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      item_q <= item_d;
      qq_q   <= qq;
      cb_q   <= COEF[idx_b];
      cab_q  <= COEF[idx_a] ^ COEF[idx_b];
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;
  assign qq_o   = qq_q;
  assign cb_o   = cb_q;
  assign cab_o  = cab_q;

endmodule

`default_nettype wire

// ----- rtl/core/pqer_solve.sv -----
// Two stages of the double erasure solve: numerator and inverse, then product
`default_nettype none

module pqer_solve (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                vld_i,
  input  wire pqer_pkg::pqer_item_t item_i,
  input  wire pqer_pkg::byte_t     qq_i,
  input  wire pqer_pkg::byte_t     cb_i,
  input  wire pqer_pkg::byte_t     cab_i,
  output logic                     vld_o,
  output pqer_pkg::pqer_item_t     item_o,
  output pqer_pkg::byte_t          ua_o
);
  import pqer_pkg::*;

  byte_t      num_d, inv_d, ua_d;
  logic       vld1_q, vld2_q;
  pqer_item_t item1_q, item2_q;
  byte_t      num_q, inv_q, ua_q;

  // stage one: Q syndrome with the second unit's share removed, inverse of ca ^ cb
  assign num_d = qq_i ^ gf_mul(cb_i, item_i.pp);
  assign inv_d = GF_INV[cab_i];
  // stage two: divide
  assign ua_d  = gf_mul(num_q, inv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      item1_q <= item_i;
      num_q   <= num_d;
      inv_q   <= inv_d;
    end
    if (vld1_q) begin
      item2_q <= item1_q;
      ua_q    <= ua_d;
    end
  end

  assign vld_o  = vld2_q;
  assign item_o = item2_q;
  assign ua_o   = ua_q;

endmodule

`default_nettype wire

// ----- rtl/core/pqer_merge.sv -----
// Output stage: drop rebuilt bytes into the column and register the result
`default_nettype none

module pqer_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 vld_i,
  input  wire pqer_pkg::pqer_item_t item_i,
  input  wire pqer_pkg::byte_t      ua_i,
  output logic                      done_o,
  output pqer_pkg::column_t         col_o,
  output pqer_pkg::byte_t           pout_o,
  output pqer_pkg::byte_t           qout_o,
  output pqer_pkg::status_t         status_o
);
  import pqer_pkg::*;

  column_t col_d;
  logic    done_q;
  column_t col_q;
  byte_t   pout_q, qout_q;
  status_t status_q;

  always_comb begin
    col_d = item_i.data;
    case (item_i.status)
      ST_ONE: begin
        col_d[item_i.idx_a] = item_i.pp;
      end
      ST_TWO: begin
        col_d[item_i.idx_a] = ua_i;
        col_d[item_i.idx_b] = item_i.pp ^ ua_i;
      end
      default: begin
        col_d = item_i.data;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      col_q    <= col_d;
      pout_q   <= item_i.pout;
      qout_q   <= item_i.qout;
      status_q <= item_i.status;
    end
  end

  assign done_o   = done_q;
  assign col_o    = col_q;
  assign pout_o   = pout_q;
  assign qout_o   = qout_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ----- rtl/core/pq_parity_erasure_rebuild_unit.sv -----
// Top level of the P+Q parity encoder and erasure rebuild pipeline
//
// Usage:
//   Requests enter on start_i together with op_i, the eight column bytes
//   data_*_i and the stored parities parity_p_in_i / parity_q_in_i. A
//   request is taken at every clock edge with start_i high and busy_o low;
//   busy_o stays low, so one column can be sent every cycle.
//   op_i low encodes: P and Q are computed, data passes through. op_i high
//   rebuilds the units flagged in lost_mask from the stored P and Q.
//   lost_mask is written through lost_mask_we_i / lost_mask_wdata_i, by the
//   user only while no request is in flight (not enforced); it resets to zero.
//   Each result appears on out_*_o, parity_*_out_o and status_o for one
//   cycle with done_o high. Throughput is one column per cycle through the
//   stages syndrome, inverse lookup, GF divide and column merge.
//   The receiver cannot stall; results are delivered in request order.
//   Reset empties the pipeline; requests in flight are dropped.
`default_nettype none

module pq_parity_erasure_rebuild_unit #(
  parameter int unsigned NUM_UNITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic       lost_mask_we_i,
  input  wire logic [7:0] lost_mask_wdata_i,
  input  wire logic       op_i,
  input  wire logic [7:0] data_0_i,
  input  wire logic [7:0] data_1_i,
  input  wire logic [7:0] data_2_i,
  input  wire logic [7:0] data_3_i,
  input  wire logic [7:0] data_4_i,
  input  wire logic [7:0] data_5_i,
  input  wire logic [7:0] data_6_i,
  input  wire logic [7:0] data_7_i,
  input  wire logic [7:0] parity_p_in_i,
  input  wire logic [7:0] parity_q_in_i,
  output logic            done_o,
  output logic [7:0]      out_0_o,
  output logic [7:0]      out_1_o,
  output logic [7:0]      out_2_o,
  output logic [7:0]      out_3_o,
  output logic [7:0]      out_4_o,
  output logic [7:0]      out_5_o,
  output logic [7:0]      out_6_o,
  output logic [7:0]      out_7_o,
  output logic [7:0]      parity_p_out_o,
  output logic [7:0]      parity_q_out_o,
  output logic [1:0]      status_o
);
  import pqer_pkg::*;

  `include "pq_parity_erasure_rebuild_unit_assert.svh"

  logic [7:0] lost_mask_q;
  column_t    data_in;
  column_t    col_out;
  logic       syn_vld, slv_vld;
  pqer_item_t syn_item, slv_item;
  byte_t      syn_qq, syn_cb, syn_cab, slv_ua;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lost_mask_q <= 8'h00;
    end else if (lost_mask_we_i) begin
      lost_mask_q <= lost_mask_wdata_i;
    end
  end

  assign busy_o = 1'b0;

  assign data_in = {data_7_i, data_6_i, data_5_i, data_4_i,
                    data_3_i, data_2_i, data_1_i, data_0_i};

  pqer_syndrome #(
    .NUM_UNITS(NUM_UNITS)
  ) u_syndrome (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (start_i && !busy_o),
    .op_i        (op_i),
    .data_i      (data_in),
    .pin_i       (parity_p_in_i),
    .qin_i       (parity_q_in_i),
    .lost_mask_i (lost_mask_q),
    .vld_o       (syn_vld),
    .item_o      (syn_item),
    .qq_o        (syn_qq),
    .cb_o        (syn_cb),
    .cab_o       (syn_cab)
  );

  pqer_solve u_solve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (syn_vld),
    .item_i (syn_item),
    .qq_i   (syn_qq),
    .cb_i   (syn_cb),
    .cab_i  (syn_cab),
    .vld_o  (slv_vld),
    .item_o (slv_item),
    .ua_o   (slv_ua)
  );

  pqer_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (slv_vld),
    .item_i   (slv_item),
    .ua_i     (slv_ua),
    .done_o   (done_o),
    .col_o    (col_out),
    .pout_o   (parity_p_out_o),
    .qout_o   (parity_q_out_o),
    .status_o (status_o)
  );

  assign out_0_o = col_out[0];
  assign out_1_o = col_out[1];
  assign out_2_o = col_out[2];
  assign out_3_o = col_out[3];
  assign out_4_o = col_out[4];
  assign out_5_o = col_out[5];
  assign out_6_o = col_out[6];
  assign out_7_o = col_out[7];

  `PQER_ASSERT(a_fixed_latency, start_i && !busy_o |-> ##4 done_o)
  `PQER_ASSERT(a_no_spurious_done, done_o |-> $past(start_i, 4))
  `PQER_ASSERT(a_two_needs_two, done_o && status_o == ST_TWO |-> $countones(lost_mask_q) >= 2)
  `PQER_NEVER(a_rebuild_without_loss, done_o && status_o != ST_NONE && lost_mask_q == 8'h00)

endmodule

`default_nettype wire
